// ===== design/f4c_pkg.sv =====
// ----------------------------------------------------------------------------
// f4c_pkg
// types, codes and helpers shared by the format-4 response frame checker
// ----------------------------------------------------------------------------
package f4c_pkg;

  localparam int unsigned MaxFrameDef = 1024;
  localparam int unsigned DelayLen    = 5;
  localparam int unsigned HeadLen     = 4;
  localparam int unsigned FifoDepth   = 4;

  localparam logic [6:0] MinLenRst   = 7'd14;
  localparam logic [3:0] MaxRetryRst = 4'd8;

  localparam logic [7:0] ChStx = 8'h02;
  localparam logic [7:0] ChEtx = 8'h03;
  localparam logic [7:0] ChAck = 8'h06;
  localparam logic [7:0] ChNak = 8'h15;
  localparam logic [7:0] ChCr  = 8'h0D;
  localparam logic [7:0] ChLf  = 8'h0A;

  typedef enum logic [1:0] {
    LEAD_IDLE = 2'd0,
    LEAD_STX  = 2'd1,
    LEAD_NAK  = 2'd2,
    LEAD_ACK  = 2'd3
  } lead_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SUM_ERR   = 3'd1,
    ST_NAK       = 3'd2,
    ST_SHORT     = 3'd3,
    ST_BAD_LEAD  = 3'd4,
    ST_EXHAUSTED = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    RP_NONE = 2'd0,
    RP_ACK  = 2'd1,
    RP_NAK  = 2'd2
  } reply_e;

  typedef enum logic [1:0] {
    CFG_MIN_LEN   = 2'd0,
    CFG_MAX_RETRY = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       first_of_request;
  } in_item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] payload_byte;
    status_e    status;
    reply_e     reply_code;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [6:0] min_frame_length;
    logic [3:0] max_retries;
  } cfg_t;

  typedef struct packed {
    logic [1:0] num;
    out_item_t  r0;
    out_item_t  r1;
  } push_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    hex_digit = (n < 4'd10) ? (8'h30 + {4'd0, n}) : (8'h37 + {4'd0, n});
  endfunction

endpackage

// ===== design/f4c_core.sv =====
// ----------------------------------------------------------------------------
// f4c_core
// frame state, running sum and tail delay line; produces up to two results
// ----------------------------------------------------------------------------
module f4c_core import f4c_pkg::*; #(
  parameter int unsigned MAX_FRAME = MaxFrameDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  in_item_t item_i,
  input  cfg_t     cfg_i,
  output push_t    push_o
);

  localparam int unsigned CntW = $clog2(MAX_FRAME + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_FRAME);

  lead_e           lead_q, lead_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [7:0]      sum_q, sum_d;
  logic [DelayLen-1:0][7:0] tail_q, tail_d;
  logic [3:0]      retry_q, retry_d;

  logic [7:0]      b, leaving, sum_chk;
  logic [3:0]      retry_base, retry_inc;
  logic            give_up, frame_end;
  logic [CntW-1:0] p;
  logic [CntW:0]   len;
  status_e         st;
  reply_e          rp;
  out_item_t       pay_r, stat_r;

  assign b          = item_i.rx_byte;
  assign retry_base = item_i.first_of_request ? 4'd0 : retry_q;
  assign retry_inc  = retry_base + 4'd1;
  assign give_up    = retry_inc >= cfg_i.max_retries;
  assign p          = cnt_q;
  assign len        = {1'b0, p} + (CntW+1)'(1);
  assign leaving    = tail_q[DelayLen-1];

  always_comb begin
    lead_d  = lead_q;
    cnt_d   = cnt_q;
    sum_d   = sum_q;
    tail_d  = tail_q;
    retry_d = retry_base;
    st      = ST_OK;
    rp      = RP_NONE;
    sum_chk = 8'd0;
    frame_end = 1'b0;
    pay_r   = '{kind: 1'b0, payload_byte: leaving, status: ST_OK,
                reply_code: RP_NONE, last: 1'b0};
    stat_r  = '{kind: 1'b1, payload_byte: 8'd0, status: ST_OK,
                reply_code: RP_NONE, last: 1'b1};
    push_o  = '{num: 2'd0, r0: pay_r, r1: stat_r};

    if (lead_q == LEAD_IDLE) begin
      tail_d    = '0;
      tail_d[0] = b;
      sum_d     = 8'd0;
      cnt_d     = CntW'(1);
      if (b == ChStx) begin
        lead_d = LEAD_STX;
      end else if (b == ChNak) begin
        lead_d = LEAD_NAK;
      end else if (b == ChAck) begin
        lead_d = LEAD_ACK;
      end else begin
        cnt_d   = '0;
        retry_d = 4'd0;
        stat_r.status = ST_BAD_LEAD;
        push_o = '{num: 2'd1, r0: stat_r, r1: stat_r};
      end
    end else begin
      cnt_d = (p < CntMax) ? p + CntW'(1) : p;
      if (lead_q != LEAD_STX) begin
        tail_d = {tail_q[DelayLen-2:0], b};
        if (b == ChLf && tail_q[0] == ChCr) begin
          if (lead_q == LEAD_NAK) begin
            retry_d = give_up ? 4'd0 : retry_inc;
            st      = give_up ? ST_EXHAUSTED : ST_NAK;
          end else begin
            retry_d = 4'd0;
            st      = ST_BAD_LEAD;
          end
          lead_d = LEAD_IDLE;
          cnt_d  = '0;
          stat_r.status = st;
          push_o = '{num: 2'd1, r0: stat_r, r1: stat_r};
        end
      end else begin
        if (p >= CntW'(DelayLen + 1)) begin
          sum_d = sum_q + leaving;
        end
        if (p >= CntW'(DelayLen + HeadLen + 1)) begin
          push_o.num = 2'd1;
        end
        frame_end = (b == ChLf) && (tail_q[0] == ChCr) &&
                    (tail_q[3] == ChEtx) && (p >= CntW'(DelayLen));
        if (frame_end) begin
          sum_chk = sum_d + tail_q[3];
          if (len < (CntW+1)'(cfg_i.min_frame_length)) begin
            retry_d = give_up ? 4'd0 : retry_inc;
            st      = give_up ? ST_EXHAUSTED : ST_SHORT;
            rp      = RP_NONE;
          end else if (hex_digit(sum_chk[7:4]) == tail_q[2] &&
                       hex_digit(sum_chk[3:0]) == tail_q[1]) begin
            retry_d = 4'd0;
            st      = ST_OK;
            rp      = RP_ACK;
          end else begin
            retry_d = give_up ? 4'd0 : retry_inc;
            st      = give_up ? ST_EXHAUSTED : ST_SUM_ERR;
            rp      = RP_NAK;
          end
          stat_r.status     = st;
          stat_r.reply_code = rp;
          if (push_o.num == 2'd1) begin
            push_o = '{num: 2'd2, r0: pay_r, r1: stat_r};
          end else begin
            push_o = '{num: 2'd1, r0: stat_r, r1: stat_r};
          end
          lead_d = LEAD_IDLE;
          cnt_d  = '0;
          sum_d  = 8'd0;
          tail_d = '0;
        end else begin
          tail_d = {tail_q[DelayLen-2:0], b};
        end
      end
    end

    if (!accept_i) begin
      push_o.num = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q  <= LEAD_IDLE;
      cnt_q   <= '0;
      sum_q   <= 8'd0;
      tail_q  <= '0;
      retry_q <= 4'd0;
    end else if (accept_i) begin
      lead_q  <= lead_d;
      cnt_q   <= cnt_d;
      sum_q   <= sum_d;
      tail_q  <= tail_d;
      retry_q <= retry_d;
    end
  end

endmodule

// ===== design/f4c_out_fifo.sv =====
// ----------------------------------------------------------------------------
// f4c_out_fifo
// small result queue, up to two pushes and one pop per cycle
// ----------------------------------------------------------------------------
module f4c_out_fifo import f4c_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  push_t     push_i,
  output logic      room2_o,
  output logic      valid_o,
  input  logic      ready_i,
  output out_item_t data_o,
  output logic [$clog2(FifoDepth+1)-1:0] count_o
);

  localparam int unsigned PtrW = $clog2(FifoDepth);
  localparam int unsigned CntW = $clog2(FifoDepth + 1);

  out_item_t [FifoDepth-1:0] mem_q;
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d, wptr_nx;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rptr_q];
  assign room2_o = cnt_q <= CntW'(FifoDepth - 2);
  assign count_o = cnt_q;
  assign wptr_nx = wptr_q + PtrW'(1);
  assign wptr_d  = wptr_q + PtrW'(push_i.num);
  assign rptr_d  = rptr_q + PtrW'(pop);
  assign cnt_d   = cnt_q + CntW'(push_i.num) - CntW'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wptr_q] <= push_i.r0;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wptr_nx] <= push_i.r1;
    end
  end

endmodule

// ===== design/format4_response_frame_checker_unit.sv =====
// ----------------------------------------------------------------------------
// format4_response_frame_checker_unit
// sum-check receiver for format-4 word-read responses with retry counting
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  in      | input     | in_valid_i / in_ready_o   | in_item_t (rx_byte, first_of_request)
//  out     | output    | out_valid_o / out_ready_i | out_item_t (kind .. last)
//  cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
//  one item per cycle while in_ready_o is high; an item's results enter a four-entry queue in the same cycle
//  the frame end item may add two results; input stalls while fewer than two slots are free
//  results are registered in the queue; from an empty queue the first shows in the cycle after the item is accepted
//  reset clears frame state, retry count, queue and loads register defaults
//  cfg writes are always taken
module format4_response_frame_checker_unit import f4c_pkg::*; #(
  parameter int unsigned MAX_FRAME = MaxFrameDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_item_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_item_t  out_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [6:0] cfg_data_i
);

  localparam int unsigned QCntW = $clog2(FifoDepth + 1);

  cfg_t             cfg_q;
  push_t            push;
  logic             accept;
  logic [QCntW-1:0] q_count;

  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_frame_length <= MinLenRst;
      cfg_q.max_retries      <= MaxRetryRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_MIN_LEN:   cfg_q.min_frame_length <= cfg_data_i;
        CFG_MAX_RETRY: cfg_q.max_retries      <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  f4c_core #(
    .MAX_FRAME (MAX_FRAME)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_data_i),
    .cfg_i    (cfg_q),
    .push_o   (push)
  );

  f4c_out_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room2_o (in_ready_o),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_data_o),
    .count_o (q_count)
  );

  a_q_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= QCntW'(FifoDepth))
    else $error("result queue over capacity");

  a_push_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |-> push.num == 2'd0)
    else $error("results pushed without an accepted item");

  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.num == 2'd2 |-> !push.r0.kind && push.r1.kind && push.r1.last)
    else $error("payload must precede status in a result pair");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.kind == out_data_o.last)
    else $error("last flag disagrees with result kind");

endmodule
